>>> hw/rtl/mono_bitmap_pack_rle_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome bitmap packer.
// Each macro expects clk in scope where used; MBP_ASSERT also needs rst_n.
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_PACK_RLE_MACROS_SVH
`define MONO_BITMAP_PACK_RLE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define MBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define MBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MBP_ASSERT(lbl, prop, msg)
`define MBP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Types and constants shared by the monochrome bitmap packer modules.
// ----------------------------------------------------------------------------
package mbp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RLE_MODE  = 2'd0;
  localparam logic [1:0] CFG_INVERT    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  // Reset value of the threshold register.
  localparam logic [7:0] THRESHOLD_RST = 8'd127;

  // Longest run in run-length mode.
  localparam logic [7:0] RUN_MAX = 8'd128;

  // One input pixel beat.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_line;
  } pixel_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // Work for the back end: one or two result bytes caused by one pixel.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } job_t;

endpackage

>>> hw/rtl/mono_bitmap_pack_rle.sv
// ----------------------------------------------------------------------------
// mono_bitmap_pack_rle
// Monochrome bitmap packer with run-length encoding, queue handshake on both
// sides and a plain register write port.
// ----------------------------------------------------------------------------
// The block takes one RGB pixel per clock whenever full is low and produces
// its result bytes through a DEPTH-entry job queue, so a stalled output does
// not stop input until the queue fills. Each pixel is classified and its
// bytes formed in the same cycle it is accepted; the first result can be
// popped in the cycle after. Output drains one byte per cycle while pop is
// high, so the sustained rate is one pixel per cycle; a pixel that gives two
// run bytes (color change on the last pixel of a line) takes two beats.
// Write the configuration registers only while no results are outstanding.
module mono_bitmap_pack_rle #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  mbp_pkg::pixel_t   in_data,
  output logic              empty,
  input  logic              pop,
  output mbp_pkg::result_t  out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  logic          accept;
  mbp_pkg::job_t job;
  logic          job_valid;
  mbp_pkg::job_t head;
  logic          head_valid;
  logic          job_done;

  assign accept = push && !full;

  // Classification and state.
  mbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pix       (in_data),
    .job       (job),
    .job_valid (job_valid)
  );

  // Job queue.
  mbp_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (job_valid),
    .job_i        (job),
    .pop_i        (job_done),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (full)
  );

  // Result serializer.
  mbp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop          (pop),
    .empty        (empty),
    .out_data     (out_data),
    .job_done_o   (job_done)
  );

endmodule

>>> hw/rtl/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front
// Holds the configuration and the packing/run state, classifies each pixel
// and produces the result bytes that the pixel causes as one job.
// ----------------------------------------------------------------------------
module mbp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                accept,
  input  mbp_pkg::pixel_t     pix,
  output mbp_pkg::job_t       job,
  output logic                job_valid
);

  logic        rle_mode_r;
  logic        invert_r;
  logic [7:0]  threshold_r;

  logic [2:0]  bit_pos_r, bit_pos_nxt;
  logic [7:0]  accum_r, accum_nxt;
  logic [23:0] run_rgb_r, run_rgb_nxt;
  logic        run_white_r, run_white_nxt;
  logic [7:0]  run_len_r, run_len_nxt;

  logic        color;
  logic [23:0] rgb;
  logic [7:0]  accum_set;
  logic        emit_old;
  logic        emit_new;
  logic [7:0]  len_base;
  logic [7:0]  len_new;
  logic        white_new;
  logic [7:0]  old_byte;
  logic [7:0]  new_byte;
  logic [7:0]  old_len_m1;
  logic [7:0]  new_len_m1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r  <= 1'b0;
      invert_r    <= 1'b0;
      threshold_r <= mbp_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbp_pkg::CFG_RLE_MODE:  rle_mode_r  <= cfg_wdata[0];
        mbp_pkg::CFG_INVERT:    invert_r    <= cfg_wdata[0];
        mbp_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pixel classification: white if any channel is above the threshold, flipped when invert is set.
  assign color = ((pix.red > threshold_r) | (pix.green > threshold_r) |
                  (pix.blue > threshold_r)) ^ invert_r;
  assign rgb   = {pix.red, pix.green, pix.blue};

  // Pack path: place the bit, a byte is complete at the eighth bit.
  always_comb begin
    accum_set = accum_r;
    accum_set[bit_pos_r] = color;
  end

  // Run path: close the open run on a color change, then extend or start one.
  assign emit_old   = (run_len_r != 8'd0) && (rgb != run_rgb_r);
  assign len_base   = emit_old ? 8'd0 : run_len_r;
  assign len_new    = len_base + 8'd1;
  assign white_new  = (len_base == 8'd0) ? color : run_white_r;
  assign emit_new   = (len_new >= mbp_pkg::RUN_MAX) || pix.end_of_line;
  assign old_len_m1 = run_len_r - 8'd1;
  assign new_len_m1 = len_new - 8'd1;
  assign old_byte   = {run_white_r, old_len_m1[6:0]};
  assign new_byte   = {white_new, new_len_m1[6:0]};

  // Next state and the job for this pixel.
  always_comb begin
    bit_pos_nxt   = bit_pos_r;
    accum_nxt     = accum_r;
    run_rgb_nxt   = run_rgb_r;
    run_white_nxt = run_white_r;
    run_len_nxt   = run_len_r;
    job.two       = 1'b0;
    job.byte0     = accum_set;
    job.byte1     = new_byte;
    job_valid     = 1'b0;
    if (accept) begin
      if (!rle_mode_r) begin
        bit_pos_nxt = bit_pos_r + 3'd1;
        if (bit_pos_r == 3'd7) begin
          accum_nxt = 8'd0;
          job_valid = 1'b1;
        end else begin
          accum_nxt = accum_set;
        end
      end else begin
        if (len_base == 8'd0) begin
          run_rgb_nxt = rgb;
        end
        run_white_nxt = white_new;
        run_len_nxt   = emit_new ? 8'd0 : len_new;
        job_valid     = emit_old | emit_new;
        job.two       = emit_old & emit_new;
        job.byte0     = emit_old ? old_byte : new_byte;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r   <= 3'd0;
      accum_r     <= 8'd0;
      run_rgb_r   <= 24'd0;
      run_white_r <= 1'b0;
      run_len_r   <= 8'd0;
    end else begin
      bit_pos_r   <= bit_pos_nxt;
      accum_r     <= accum_nxt;
      run_rgb_r   <= run_rgb_nxt;
      run_white_r <= run_white_nxt;
      run_len_r   <= run_len_nxt;
    end
  end

endmodule

>>> hw/rtl/mbp_fifo.sv
// ----------------------------------------------------------------------------
// mbp_fifo
// Short job queue between the front end and the result serializer.
// ----------------------------------------------------------------------------
`include "mono_bitmap_pack_rle_macros.svh"

module mbp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  mbp_pkg::job_t   job_i,
  input  logic            pop_i,
  output mbp_pkg::job_t   head_o,
  output logic            head_valid_o,
  output logic            full_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mbp_pkg::job_t  mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + CW'(1);
    end else if (!push_i && pop_i) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  assign head_o       = mem_r[rd_ptr_r];
  assign head_valid_o = (count_r != '0);
  assign full_o       = (count_r == CW'(DEPTH));

  `MBP_ASSERT(a_count_in_range, count_r <= CW'(DEPTH), "job queue count above depth")
  `MBP_ASSERT(a_no_pop_empty, pop_i |-> (count_r != '0), "job queue popped while empty")
  `MBP_ASSERT(a_push_grows, push_i && !pop_i |=> count_r == $past(count_r) + CW'(1), "push lost")

endmodule

>>> hw/rtl/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back
// Result serializer: presents the head job's bytes one beat at a time and
// marks the final byte of each job.
// ----------------------------------------------------------------------------
`include "mono_bitmap_pack_rle_macros.svh"

module mbp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mbp_pkg::job_t     head_i,
  input  logic              head_valid_i,
  input  logic              pop,
  output logic              empty,
  output mbp_pkg::result_t  out_data,
  output logic              job_done_o
);

  logic second_r, second_nxt;
  logic take;

  assign empty = !head_valid_i;
  assign take  = pop && head_valid_i;

  // Select the byte; the first of a two-byte job is not the last.
  always_comb begin
    out_data.out_byte = second_r ? head_i.byte1 : head_i.byte0;
    out_data.last     = second_r || !head_i.two;
  end

  // Step through the job's bytes as they are taken.
  always_comb begin
    second_nxt = second_r;
    job_done_o = 1'b0;
    if (take) begin
      if (!second_r && head_i.two) begin
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        job_done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

  `MBP_ASSERT(a_second_has_job, second_r |-> (head_valid_i && head_i.two), "second byte without a two-byte job")

endmodule

>>> tb/mono_bitmap_pack_rle_test.sv
// ----------------------------------------------------------------------------
// mono_bitmap_pack_rle_test
// Self-checking bench for the monochrome bitmap packer. Pixels go in through
// the push/full queue port, and bytes come out through the empty/pop port.
// A byte tracker class keeps its own copy of the packer and run-length state,
// works out the bytes each accepted pixel should give, and compares every
// popped byte against the oldest one still owed. A short directed part covers
// the corner cases. Random lines of color runs follow, under changing register
// settings, with random gaps on both sides and a long output hold-off every sixth phase.
// ----------------------------------------------------------------------------
module mono_bitmap_pack_rle_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbp_pkg::*;

  localparam int RANDOM_PIXELS = 1300;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 100;

  // Tracks the expected output bytes of the packer.
  class byte_tracker;
    logic        rle_on;
    logic        invert_on;
    logic [7:0]  level;
    logic [2:0]  bit_pos;
    logic [7:0]  pack_byte;
    logic [23:0] run_rgb;
    logic        run_white;
    logic [7:0]  run_len;
    result_t     pending_bytes[$];
    int          mismatches;

    function new();
      rle_on     = 1'b0;
      invert_on  = 1'b0;
      level      = THRESHOLD_RST;
      bit_pos    = 3'd0;
      pack_byte  = 8'd0;
      run_rgb    = 24'd0;
      run_white  = 1'b0;
      run_len    = 8'd0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        CFG_RLE_MODE:  rle_on = value[0];
        CFG_INVERT:    invert_on = value[0];
        CFG_THRESHOLD: level = value;
        default: ;
      endcase
    endfunction

    // Emits the open run as color in bit 7 and length minus one below it.
    function void close_run();
      logic [7:0] len_m1;
      result_t    run_byte;
      len_m1 = run_len - 8'd1;
      run_byte.out_byte = {run_white, len_m1[6:0]};
      run_byte.last = 1'b0;
      pending_bytes.push_back(run_byte);
      run_len = 8'd0;
    endfunction

    function void take_pixel(pixel_t p);
      logic        white;
      logic [23:0] rgb;
      int          queued_n;
      result_t     tail;
      queued_n = pending_bytes.size();
      white = ((p.red > level) || (p.green > level) || (p.blue > level)) ^ invert_on;
      rgb = {p.red, p.green, p.blue};
      if (!rle_on) begin
        // Pack mode fills LSB first; end of line plays no part here.
        pack_byte[bit_pos] = white;
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          tail.out_byte = pack_byte;
          tail.last = 1'b0;
          pending_bytes.push_back(tail);
          pack_byte = 8'd0;
        end
      end else begin
        // A color change closes the open run before this pixel starts a new one.
        if (run_len != 8'd0 && rgb != run_rgb) close_run();
        if (run_len == 8'd0) begin
          run_rgb = rgb;
          run_white = white;
        end
        run_len = run_len + 8'd1;
        if (run_len >= RUN_MAX || p.end_of_line) close_run();
      end
      // The final byte caused by this pixel carries the last flag.
      if (pending_bytes.size() > queued_n) begin
        tail = pending_bytes.pop_back();
        tail.last = 1'b1;
        pending_bytes.push_back(tail);
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void match_byte(result_t got);
      result_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                   $time, got.out_byte, got.last);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: out_byte expected %02h, got %02h",
                   $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  pixel_t     in_data;
  logic       empty;
  logic       pop;
  result_t    out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  byte_tracker sb;
  bit          hold_off_req;
  bit          sender_steady;
  bit          sink_steady;

  mono_bitmap_pack_rle dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic pixel_t pix(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic eol);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.end_of_line = eol;
    return p;
  endfunction

  // Offers one pixel until the block takes it, then idles for a random gap.
  task automatic send_pixel(pixel_t p);
    int gap;
    push <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (full);
    sb.take_pixel(p);
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed byte has been popped.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back; unused upper bits get noise.
  task automatic write_config(logic mode, logic inv, logic [7:0] thr);
    logic [7:0] value;
    cfg_we <= 1'b1;
    value = {7'($urandom_range(0, 127)), mode};
    cfg_index <= CFG_RLE_MODE;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(CFG_RLE_MODE, value);
    value = {7'($urandom_range(0, 127)), inv};
    cfg_index <= CFG_INVERT;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(CFG_INVERT, value);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    sb.write_reg(CFG_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  // Checks every byte beat taken by the receiver.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.match_byte(out_data);
  end

  // Receiver: random pop stalls, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        stall = 0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap(sink_steady);
      end
    end
  end

  // Guard against a hung run.
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus.
  initial begin
    int          sent;
    int          phase;
    int          phase_len;
    int          line_left;
    int          run_left;
    int          roll;
    logic [7:0]  thr;
    logic [23:0] palette[4];
    logic [23:0] color;
    pixel_t      p;

    sb = new();
    hold_off_req = 1'b0;
    sender_steady = 1'b0;
    sink_steady = 1'b0;
    rst_n <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RLE_MODE;
    cfg_wdata <= 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pack mode at reset settings: channel edges around the threshold, an
    // ignored end of line, one full byte and then a trailing partial byte.
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(pix(8'd128, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd128, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd0, 8'd128, 1'b0));
    send_pixel(pix(8'd127, 8'd127, 8'd127, 1'b1));
    send_pixel(pix(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd1, 8'd2, 8'd3, 1'b1));
    send_pixel(pix(8'd200, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd255, 8'd0, 1'b1));

    // Run-length mode: color change on the last pixel of a line gives two
    // bytes, a one-pixel line, and a run left open across a register change.
    settle();
    write_config(1'b1, 1'b1, 8'd0);
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd10, 8'd0, 8'd0, 1'b1));
    send_pixel(pix(8'd5, 8'd5, 8'd5, 1'b1));
    send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(pix(8'd255, 8'd255, 8'd254, 1'b0));
    settle();
    write_config(1'b1, 1'b0, 8'd255);
    send_pixel(pix(8'd255, 8'd255, 8'd254, 1'b0));
    send_pixel(pix(8'd255, 8'd255, 8'd254, 1'b1));

    // Back to pack mode: the partial byte from before resumes.
    settle();
    write_config(1'b0, 1'b1, 8'd255);
    repeat (5)
      send_pixel(pix(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));

    // Random phases of lines made of color runs, with some noise pixels.
    sent = 0;
    phase = 0;
    line_left = 0;
    run_left = 0;
    color = 24'd0;
    while (sent < RANDOM_PIXELS) begin
      settle();
      roll = $urandom_range(0, 3);
      thr = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom);
      write_config(1'($urandom), 1'($urandom), thr);
      foreach (palette[i]) palette[i] = 24'($urandom);
      sender_steady = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      if (phase % 6 == 1) begin
        // Receiver holds off while the sender keeps pushing back to back.
        hold_off_req = 1'b1;
        sender_steady = 1'b1;
      end
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        if (line_left == 0)
          line_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                                   : $urandom_range(120, 300);
        if (run_left == 0) begin
          roll = $urandom_range(0, 99);
          color = (roll < 70) ? palette[$urandom_range(0, 3)] : 24'($urandom);
          roll = $urandom_range(0, 99);
          run_left = (roll < 60) ? $urandom_range(1, 4) :
                     (roll < 90) ? $urandom_range(5, 30) : $urandom_range(100, 260);
        end
        if ($urandom_range(0, 99) < 8) begin
          p = pix(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          p = pix(color[23:16], color[15:8], color[7:0], line_left == 1);
          run_left--;
          line_left--;
        end
        send_pixel(p);
        sent++;
      end
      phase++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
